@@ hdl/lcp_pkg.sv @@
package lcp_pkg;

  // Input coordinate width, 8 fraction bits
  localparam int COORD_BITS = 16;

  // Internal widths
  localparam int PtW     = COORD_BITS + 1;               // line point or point plus direction
  localparam int ProdW   = 16 + PtW;                     // rotation term
  localparam int CamW    = ((ProdW > 30) ? ProdW : 30) + 2;  // camera coordinate, 22 frac bits
  localparam int NxQW    = 32;                           // quotient bits, 17 frac bits
  localparam int NxDivW  = CamW + NxQW;
  localparam int NxW     = 32;                           // normalized coordinate, 16 frac bits
  localparam int KpW     = 48;
  localparam int PixW    = 50;                           // pixel, 20 frac bits
  localparam int DiffW   = 51;
  localparam int ScaleW  = 30;
  localparam int SqW     = 2 * ScaleW;
  localparam int SumW    = SqW + 2;
  localparam int RootW   = SumW / 2;
  localparam int DirQW   = 15;
  localparam int DirDivW = RootW + DirQW;
  localparam int NormSteps = 5;
  localparam int PixOutW = 20;
  localparam int DirW    = 16;
  localparam int RegIdxW = 3;
  localparam int CfgW    = 64;

  localparam logic [DirQW-1:0] DirOne = DirQW'(16384);

  typedef enum logic [RegIdxW-1:0] {
    RegPoseRow0      = 3'd0,
    RegPoseRow1      = 3'd1,
    RegPoseRow2      = 3'd2,
    RegIntrinsicRow0 = 3'd3,
    RegIntrinsicRow1 = 3'd4,
    RegIntrinsicRow2 = 3'd5
  } lcp_reg_e;

  typedef enum logic [1:0] {
    FaultOk    = 2'd0,
    FaultDepth = 2'd1,
    FaultFlat  = 2'd2
  } lcp_fault_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] direction_x;
    logic signed [COORD_BITS-1:0] direction_y;
    logic signed [COORD_BITS-1:0] direction_z;
  } lcp_in_t;

  typedef struct packed {
    logic signed [PixOutW-1:0] image_x;
    logic signed [PixOutW-1:0] image_y;
    logic signed [DirW-1:0]    image_dir_x;
    logic signed [DirW-1:0]    image_dir_y;
    lcp_fault_e                fault;
  } lcp_out_t;

  // Travels beside the perspective divider
  typedef struct packed {
    logic       depth_bad;
    logic [3:0] sat;
    logic [3:0] neg;
  } lcp_nx_side_t;

  // Travels beside the direction normalizer
  typedef struct packed {
    logic [PixOutW-1:0] ix;
    logic [PixOutW-1:0] iy;
    logic               neg_x;
    logic               neg_y;
    lcp_fault_e         fault;
  } lcp_side_t;

endpackage

@@ hdl/line_camera_projection_unit.sv @@
// Line camera projection unit.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one 3D line per beat:
// a point and a direction. Output channel (out_valid_o / out_stall_i / out_data_o)
// gives the pixel of the point, the unit image direction and a fault code.
// Pose [R|t] and the first two rows of K are written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must write them only while no line is in
// flight, which the block does not enforce. Throughput: one line per clock while
// the output is not stalled. The pipeline holds three bit-per-stage units: the
// 32-step perspective divider, the 31-step square root and the 15-step direction
// divider. Reset clears all configuration to zero and empties the pipeline.
// When the receiver stalls a valid output beat, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing in flight is lost or repeated.
module line_camera_projection_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lcp_pkg::RegIdxW-1:0]        cfg_index_i,
  input  logic [lcp_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  lcp_pkg::lcp_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output lcp_pkg::lcp_out_t                  out_data_o
);

  import lcp_pkg::*;

  function automatic logic [PixOutW-1:0] to_pixel(input logic signed [PixW-1:0] v);
    logic [PixW-1:0] m_in;
    logic [PixW-16:0] m;
    logic [PixOutW-1:0] r;
    m_in = v[PixW-1] ? PixW'(-v) : PixW'(v);
    m    = (PixW-15)'(({1'b0, m_in} + (PixW+1)'(1 << 15)) >> 16);
    if (v[PixW-1]) begin
      r = (m > (PixW-15)'(524288)) ? PixOutW'(524288) : PixOutW'((PixW-15)'(0) - m);
    end else begin
      r = (m > (PixW-15)'(524287)) ? PixOutW'(524287) : m[PixOutW-1:0];
    end
    return r;
  endfunction

  logic adv;
  logic out_valid_q;
  lcp_out_t out_data_q, out_data_d;

  // whole pipeline moves unless the output beat is held
  assign adv        = ~(out_valid_q & out_stall_i);
  assign in_stall_o = ~adv;

  // Configuration registers
  logic [CfgW-1:0] pose_q [3];
  logic [47:0]     intr_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) pose_q[i] <= '0;
      for (int i = 0; i < 2; i++) intr_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegPoseRow0:      pose_q[0] <= cfg_data_i;
        RegPoseRow1:      pose_q[1] <= cfg_data_i;
        RegPoseRow2:      pose_q[2] <= cfg_data_i;
        RegIntrinsicRow0: intr_q[0] <= cfg_data_i[47:0];
        RegIntrinsicRow1: intr_q[1] <= cfg_data_i[47:0];
        RegIntrinsicRow2: ;  // third row of K is taken as 0 0 1
        default:          ;
      endcase
    end
  end

  // Stage 0: points A and B = A + D
  logic                    s0_valid_q;
  logic signed [PtW-1:0]   s0_pt_q [2][3];
  logic signed [PtW-1:0]   s0_pt_d [2][3];

  always_comb begin
    s0_pt_d[0][0] = PtW'(in_data_i.point_x);
    s0_pt_d[0][1] = PtW'(in_data_i.point_y);
    s0_pt_d[0][2] = PtW'(in_data_i.point_z);
    s0_pt_d[1][0] = PtW'(in_data_i.point_x) + PtW'(in_data_i.direction_x);
    s0_pt_d[1][1] = PtW'(in_data_i.point_y) + PtW'(in_data_i.direction_y);
    s0_pt_d[1][2] = PtW'(in_data_i.point_z) + PtW'(in_data_i.direction_z);
  end

  // Stage 1: rotation products
  logic                    s1_valid_q;
  logic signed [ProdW-1:0] s1_prod_q [2][3][3];
  logic signed [ProdW-1:0] s1_prod_d [2][3][3];

  always_comb begin
    logic signed [15:0] rot;
    for (int p = 0; p < 2; p++) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rot = pose_q[i][16*j +: 16];
          s1_prod_d[p][i][j] = ProdW'(rot) * ProdW'(s0_pt_q[p][j]);
        end
      end
    end
  end

  // Stage 2: camera coordinates, 22 fraction bits
  logic                   s2_valid_q;
  logic signed [CamW-1:0] s2_cam_q [2][3];
  logic signed [CamW-1:0] s2_cam_d [2][3];

  always_comb begin
    logic signed [15:0] tr;
    for (int p = 0; p < 2; p++) begin
      for (int i = 0; i < 3; i++) begin
        tr = pose_q[i][63:48];
        s2_cam_d[p][i] = (CamW'(tr) <<< 14) + CamW'(s1_prod_q[p][i][0])
                       + CamW'(s1_prod_q[p][i][1]) + CamW'(s1_prod_q[p][i][2]);
      end
    end
  end

  // Stage 3: divider operands; lanes are A.x, A.y, B.x, B.y
  logic                           s3_valid_q;
  logic [3:0][NxDivW-1:0]         s3_num_q, s3_num_d;
  logic [3:0][CamW-1:0]           s3_den_q, s3_den_d;
  lcp_nx_side_t                   s3_side_q, s3_side_d;

  always_comb begin
    logic [CamW-1:0]        den;
    logic [CamW-1:0]        nm;
    logic signed [CamW-1:0] c;
    int                     l;
    s3_side_d.depth_bad = (s2_cam_q[0][2] <= 0) || (s2_cam_q[1][2] <= 0);
    s3_side_d.sat       = '0;
    s3_side_d.neg       = '0;
    for (int p = 0; p < 2; p++) begin
      den = s2_cam_q[p][2][CamW-1] ? CamW'(-s2_cam_q[p][2]) : CamW'(s2_cam_q[p][2]);
      for (int q = 0; q < 2; q++) begin
        l  = 2 * p + q;
        c  = s2_cam_q[p][q];
        nm = c[CamW-1] ? CamW'(-c) : CamW'(c);
        s3_side_d.neg[l] = c[CamW-1];
        // integer part of 2^15 or more saturates
        s3_side_d.sat[l] = NxDivW'(nm) >= (NxDivW'(den) << 15);
        s3_num_d[l] = s3_side_d.sat[l] ? '0 : (NxDivW'(nm) << 17);
        s3_den_d[l] = den;
      end
    end
  end

  // Perspective divider
  logic                    d1_valid;
  logic [3:0][NxQW-1:0]    d1_quot;
  lcp_nx_side_t            d1_side;

  lcp_div_pipe #(
    .LANES  (4),
    .DEN_W  (CamW),
    .Q_W    (NxQW),
    .SIDE_W ($bits(lcp_nx_side_t))
  ) u_nx_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_valid_q),
    .num_i   (s3_num_q),
    .den_i   (s3_den_q),
    .side_i  (s3_side_q),
    .valid_o (d1_valid),
    .quot_o  (d1_quot),
    .side_o  (d1_side)
  );

  // Stage 4: round half away, saturate, sign
  logic                  s4_valid_q;
  logic signed [NxW-1:0] s4_nx_q [4];
  logic signed [NxW-1:0] s4_nx_d [4];
  logic                  s4_bad_q;

  always_comb begin
    logic [NxQW:0]  rnd;
    logic [NxW-1:0] rq;
    for (int l = 0; l < 4; l++) begin
      rnd = {1'b0, d1_quot[l]} + (NxQW+1)'(1);
      rq  = rnd[NxQW:1];
      if (d1_side.sat[l] || rq[NxW-1]) rq = {1'b0, {(NxW-1){1'b1}}};
      s4_nx_d[l] = d1_side.neg[l] ? NxW'(-rq) : NxW'(rq);
    end
  end

  // Stage 5: intrinsic products
  logic                  s5_valid_q;
  logic signed [KpW-1:0] s5_kp_q [2][2][2];
  logic signed [KpW-1:0] s5_kp_d [2][2][2];
  logic                  s5_bad_q;

  always_comb begin
    logic signed [15:0] k0, k1;
    for (int p = 0; p < 2; p++) begin
      for (int r = 0; r < 2; r++) begin
        k0 = intr_q[r][15:0];
        k1 = intr_q[r][31:16];
        s5_kp_d[p][r][0] = KpW'(k0) * KpW'(s4_nx_q[2*p]);
        s5_kp_d[p][r][1] = KpW'(k1) * KpW'(s4_nx_q[2*p+1]);
      end
    end
  end

  // Stage 6: pixels, 20 fraction bits
  logic                   s6_valid_q;
  logic signed [PixW-1:0] s6_pix_q [2][2];
  logic signed [PixW-1:0] s6_pix_d [2][2];
  logic                   s6_bad_q;

  always_comb begin
    logic signed [15:0] k2;
    for (int p = 0; p < 2; p++) begin
      for (int r = 0; r < 2; r++) begin
        k2 = intr_q[r][47:32];
        s6_pix_d[p][r] = PixW'(s5_kp_q[p][r][0]) + PixW'(s5_kp_q[p][r][1])
                       + (PixW'(k2) <<< 16);
      end
    end
  end

  // Stage 7 and range reduction: difference magnitudes shifted below 2^30
  logic              sh_valid_q [NormSteps+1];
  logic [DiffW-1:0]  sh_a_q     [NormSteps+1];
  logic [DiffW-1:0]  sh_b_q     [NormSteps+1];
  lcp_side_t         sh_side_q  [NormSteps+1];
  logic [DiffW-1:0]  s7_a_d, s7_b_d;
  lcp_side_t         s7_side_d;

  always_comb begin
    logic signed [DiffW-1:0] du, dv;
    du = DiffW'(s6_pix_q[1][0]) - DiffW'(s6_pix_q[0][0]);
    dv = DiffW'(s6_pix_q[1][1]) - DiffW'(s6_pix_q[0][1]);
    s7_a_d = du[DiffW-1] ? DiffW'(-du) : DiffW'(du);
    s7_b_d = dv[DiffW-1] ? DiffW'(-dv) : DiffW'(dv);
    s7_side_d.neg_x = du[DiffW-1];
    s7_side_d.neg_y = dv[DiffW-1];
    if (s6_bad_q) begin
      s7_side_d.ix    = '0;
      s7_side_d.iy    = '0;
      s7_side_d.fault = FaultDepth;
    end else begin
      s7_side_d.ix    = to_pixel(s6_pix_q[0][0]);
      s7_side_d.iy    = to_pixel(s6_pix_q[0][1]);
      s7_side_d.fault = (du == '0 && dv == '0) ? FaultFlat : FaultOk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sh_a_q[0]    <= s7_a_d;
      sh_b_q[0]    <= s7_b_d;
      sh_side_q[0] <= s7_side_d;
    end
  end

  // binary shift search: 16, 8, 4, 2, 1
  for (genvar k = 1; k <= NormSteps; k++) begin : g_norm
    localparam int Sh = 1 << (NormSteps - k);
    logic big;
    assign big = |((sh_a_q[k-1] | sh_b_q[k-1]) >> (ScaleW - 1 + Sh));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sh_valid_q[k] <= 1'b0;
      end else if (adv) begin
        sh_valid_q[k] <= sh_valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sh_a_q[k]    <= big ? (sh_a_q[k-1] >> Sh) : sh_a_q[k-1];
        sh_b_q[k]    <= big ? (sh_b_q[k-1] >> Sh) : sh_b_q[k-1];
        sh_side_q[k] <= sh_side_q[k-1];
      end
    end
  end

  // Stage 8: squares
  logic              sq_valid_q;
  logic [SqW-1:0]    sq_a_q, sq_b_q;
  logic [ScaleW-1:0] sq_ma_q, sq_mb_q;
  lcp_side_t         sq_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_a_q    <= SqW'(sh_a_q[NormSteps][ScaleW-1:0]) * SqW'(sh_a_q[NormSteps][ScaleW-1:0]);
      sq_b_q    <= SqW'(sh_b_q[NormSteps][ScaleW-1:0]) * SqW'(sh_b_q[NormSteps][ScaleW-1:0]);
      sq_ma_q   <= sh_a_q[NormSteps][ScaleW-1:0];
      sq_mb_q   <= sh_b_q[NormSteps][ScaleW-1:0];
      sq_side_q <= sh_side_q[NormSteps];
    end
  end

  // Square root: index 0 holds the sum, then one root bit per stage
  logic              rt_valid_q [RootW+1];
  logic [SumW-1:0]   rt_rem_q   [RootW+1];
  logic [RootW-1:0]  rt_root_q  [RootW+1];
  logic [ScaleW-1:0] rt_a_q     [RootW+1];
  logic [ScaleW-1:0] rt_b_q     [RootW+1];
  lcp_side_t         rt_side_q  [RootW+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rt_rem_q[0]  <= SumW'(sq_a_q) + SumW'(sq_b_q);
      rt_root_q[0] <= '0;
      rt_a_q[0]    <= sq_ma_q;
      rt_b_q[0]    <= sq_mb_q;
      rt_side_q[0] <= sq_side_q;
    end
  end

  for (genvar k = 1; k <= RootW; k++) begin : g_sqrt
    localparam int Bit = RootW - k;
    logic [SumW-1:0] trial;
    logic            fits;
    assign trial = (SumW'(rt_root_q[k-1]) << (Bit + 1)) + (SumW'(1) << (2 * Bit));
    assign fits  = rt_rem_q[k-1] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_valid_q[k] <= 1'b0;
      end else if (adv) begin
        rt_valid_q[k] <= rt_valid_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rt_rem_q[k]  <= fits ? (rt_rem_q[k-1] - trial) : rt_rem_q[k-1];
        rt_root_q[k] <= fits ? (rt_root_q[k-1] | (RootW'(1) << Bit)) : rt_root_q[k-1];
        rt_a_q[k]    <= rt_a_q[k-1];
        rt_b_q[k]    <= rt_b_q[k-1];
        rt_side_q[k] <= rt_side_q[k-1];
      end
    end
  end

  // Direction divider operands: (m * 2^14 + n/2) / n
  logic [RootW-1:0]              nrm;
  logic [1:0][DirDivW-1:0]       dir_num;
  logic [1:0][RootW-1:0]         dir_den;

  assign nrm        = (rt_root_q[RootW] == '0) ? RootW'(1) : rt_root_q[RootW];
  assign dir_num[0] = (DirDivW'(rt_a_q[RootW]) << 14) + DirDivW'(nrm >> 1);
  assign dir_num[1] = (DirDivW'(rt_b_q[RootW]) << 14) + DirDivW'(nrm >> 1);
  assign dir_den[0] = nrm;
  assign dir_den[1] = nrm;

  logic                   d2_valid;
  logic [1:0][DirQW-1:0]  d2_quot;
  lcp_side_t              d2_side;

  lcp_div_pipe #(
    .LANES  (2),
    .DEN_W  (RootW),
    .Q_W    (DirQW),
    .SIDE_W ($bits(lcp_side_t))
  ) u_dir_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (rt_valid_q[RootW]),
    .num_i   (dir_num),
    .den_i   (dir_den),
    .side_i  (rt_side_q[RootW]),
    .valid_o (d2_valid),
    .quot_o  (d2_quot),
    .side_o  (d2_side)
  );

  // Output stage: clamp, sign, fault masking
  always_comb begin
    logic [DirQW-1:0] qx, qy;
    qx = (d2_quot[0] > DirOne) ? DirOne : d2_quot[0];
    qy = (d2_quot[1] > DirOne) ? DirOne : d2_quot[1];
    out_data_d.image_x = d2_side.ix;
    out_data_d.image_y = d2_side.iy;
    out_data_d.fault   = d2_side.fault;
    if (d2_side.fault != FaultOk) begin
      out_data_d.image_dir_x = '0;
      out_data_d.image_dir_y = '0;
    end else begin
      out_data_d.image_dir_x = d2_side.neg_x ? -DirW'(qx) : DirW'(qx);
      out_data_d.image_dir_y = d2_side.neg_y ? -DirW'(qy) : DirW'(qy);
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q    <= 1'b0;
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      s3_valid_q    <= 1'b0;
      s4_valid_q    <= 1'b0;
      s5_valid_q    <= 1'b0;
      s6_valid_q    <= 1'b0;
      sh_valid_q[0] <= 1'b0;
      sq_valid_q    <= 1'b0;
      rt_valid_q[0] <= 1'b0;
      out_valid_q   <= 1'b0;
    end else if (adv) begin
      s0_valid_q    <= in_valid_i;
      s1_valid_q    <= s0_valid_q;
      s2_valid_q    <= s1_valid_q;
      s3_valid_q    <= s2_valid_q;
      s4_valid_q    <= d1_valid;
      s5_valid_q    <= s4_valid_q;
      s6_valid_q    <= s5_valid_q;
      sh_valid_q[0] <= s6_valid_q;
      sq_valid_q    <= sh_valid_q[NormSteps];
      rt_valid_q[0] <= sq_valid_q;
      out_valid_q   <= d2_valid;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_pt_q    <= s0_pt_d;
      s1_prod_q  <= s1_prod_d;
      s2_cam_q   <= s2_cam_d;
      s3_num_q   <= s3_num_d;
      s3_den_q   <= s3_den_d;
      s3_side_q  <= s3_side_d;
      s4_nx_q    <= s4_nx_d;
      s4_bad_q   <= d1_side.depth_bad;
      s5_kp_q    <= s5_kp_d;
      s5_bad_q   <= s4_bad_q;
      s6_pix_q   <= s6_pix_d;
      s6_bad_q   <= s5_bad_q;
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A depth fault carries no pixel and no direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fault == FaultDepth)
      |-> (out_data_o.image_x == '0 && out_data_o.image_y == '0))
    else $error("depth fault with nonzero pixel");

  // Any fault clears the direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fault != FaultOk)
      |-> (out_data_o.image_dir_x == '0 && out_data_o.image_dir_y == '0))
    else $error("fault with nonzero direction");

  // A good line always has a nonzero unit direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.fault == FaultOk)
      |-> (out_data_o.image_dir_x != '0 || out_data_o.image_dir_y != '0))
    else $error("zero direction without fault");

endmodule

@@ hdl/lcp_div_pipe.sv @@
module lcp_div_pipe #(
  parameter int LANES  = 1,
  parameter int DEN_W  = 8,
  parameter int Q_W    = 8,
  parameter int SIDE_W = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [LANES-1:0][DEN_W+Q_W-1:0]     num_i,
  input  logic [LANES-1:0][DEN_W-1:0]         den_i,
  input  logic [SIDE_W-1:0]                   side_i,
  output logic                                valid_o,
  output logic [LANES-1:0][Q_W-1:0]           quot_o,
  output logic [SIDE_W-1:0]                   side_o
);

  // Restoring divider, one quotient bit per stage, MSB first.
  // Numerator must be below den * 2^Q_W.
  localparam int RemW = DEN_W + Q_W;

  logic                             valid_q [Q_W];
  logic [LANES-1:0][RemW-1:0]       rem_q   [Q_W];
  logic [LANES-1:0][DEN_W-1:0]      den_q   [Q_W];
  logic [LANES-1:0][Q_W-1:0]        quot_q  [Q_W];
  logic [SIDE_W-1:0]                side_q  [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int Bit = Q_W - 1 - k;

    logic                       valid_in;
    logic [LANES-1:0][RemW-1:0] rem_in, rem_d;
    logic [LANES-1:0][DEN_W-1:0] den_in;
    logic [LANES-1:0][Q_W-1:0]  quot_in, quot_d;
    logic [SIDE_W-1:0]          side_in;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = num_i;
      assign den_in   = den_i;
      assign quot_in  = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign den_in   = den_q[k-1];
      assign quot_in  = quot_q[k-1];
      assign side_in  = side_q[k-1];
    end

    // trial subtract of den shifted to this bit
    always_comb begin
      logic [RemW-1:0] trial;
      rem_d  = rem_in;
      quot_d = quot_in;
      for (int l = 0; l < LANES; l++) begin
        trial = RemW'(den_in[l]) << Bit;
        if (rem_in[l] >= trial) begin
          rem_d[l]       = rem_in[l] - trial;
          quot_d[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quot_q[k] <= quot_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[Q_W-1];
  assign quot_o  = quot_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

@@ bench/testbench.sv @@
module testbench;
  import lcp_pkg::*;

  localparam int PipeDelay  = 94;
  localparam int CycleLimit = 600000;
  localparam int NumModes   = 4;
  localparam int LinesPerPhase = 112;
  localparam logic [RegIdxW-1:0] SpareIdx6 = 3'd6;
  localparam logic [RegIdxW-1:0] SpareIdx7 = 3'd7;
  localparam longint unsigned QSat = 64'd2147483647;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [RegIdxW-1:0] cfg_index;
  logic [CfgW-1:0]   cfg_data;
  logic              in_valid;
  logic              in_stall;
  lcp_in_t           in_data;
  logic              out_valid;
  logic              out_stall;
  lcp_out_t          out_data;

  line_camera_projection_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // Shadow copy of the pose and intrinsic registers
  logic [63:0] pose_rows[3];
  logic [47:0] k_rows[3];

  lcp_out_t pending_pixels[$];
  int       errors;
  int       lines_sent;
  int       beats_checked;
  int       depth_faults;
  int       flat_faults;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------- predictor ----------------
  function automatic longint sub16(logic [63:0] w, int idx);
    logic signed [15:0] f;
    f = w[idx*16 +: 16];
    return longint'(f);
  endfunction

  // Perspective division, 16 fraction bits, rounded half away from zero, saturated
  function automatic longint persp_div(longint num, longint den);
    longint unsigned n, d, q, r;
    n = (num < 0) ? longint'(-num) : num;
    d = den;
    q = n / d;
    r = n % d;
    if (q >= 64'd32768) begin
      q = QSat;
    end else begin
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 64'd1;
        end
      end
      if ((r << 1) >= d) q = q + 1;
      if (q > QSat) q = QSat;
    end
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bt;
    res = 0;
    bt = 64'h4000_0000_0000_0000;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Camera transform and pinhole mapping; pixel at 20 fraction bits
  function automatic bit map_point(input longint p[3], output longint pu, output longint pv);
    longint cam[3];
    longint nx, ny;
    pu = 0;
    pv = 0;
    for (int i = 0; i < 3; i++) begin
      cam[i] = sub16(pose_rows[i], 3) * 16384;
      for (int j = 0; j < 3; j++) cam[i] += sub16(pose_rows[i], j) * p[j];
    end
    if (cam[2] <= 0) return 1'b0;
    nx = persp_div(cam[0], cam[2]);
    ny = persp_div(cam[1], cam[2]);
    pu = sub16(k_rows[0], 0) * nx + sub16(k_rows[0], 1) * ny + sub16(k_rows[0], 2) * 65536;
    pv = sub16(k_rows[1], 0) * nx + sub16(k_rows[1], 1) * ny + sub16(k_rows[1], 2) * 65536;
    return 1'b1;
  endfunction

  function automatic longint round_pixel(longint v);
    longint unsigned m;
    m = ((v < 0) ? longint'(-v) : v) + 64'd32768;
    m = m >> 16;
    if (v < 0) return (m > 64'd524288) ? -524288 : -longint'(m);
    return (m > 64'd524287) ? 524287 : longint'(m);
  endfunction

  function automatic longint unit_part(longint c, longint unsigned a, longint unsigned n);
    longint unsigned q;
    q = ((a << 14) + (n >> 1)) / n;
    if (q > 64'd16384) q = 64'd16384;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic lcp_out_t project_line(lcp_in_t v);
    longint pa[3], pb[3];
    longint u0, v0, u1, v1, du, dv;
    longint unsigned ma, mb, mx, n;
    int s;
    bit ok_a, ok_b;
    lcp_out_t r;
    r = '0;
    r.fault = FaultOk;
    pa[0] = v.point_x;
    pa[1] = v.point_y;
    pa[2] = v.point_z;
    pb[0] = pa[0] + longint'(v.direction_x);
    pb[1] = pa[1] + longint'(v.direction_y);
    pb[2] = pa[2] + longint'(v.direction_z);
    ok_a = map_point(pa, u0, v0);
    ok_b = map_point(pb, u1, v1);
    if (!ok_a || !ok_b) begin
      r.fault = FaultDepth;
      return r;
    end
    r.image_x = PixOutW'(round_pixel(u0));
    r.image_y = PixOutW'(round_pixel(v0));
    du = u1 - u0;
    dv = v1 - v0;
    if (du == 0 && dv == 0) begin
      r.fault = FaultFlat;
      return r;
    end
    ma = (du < 0) ? longint'(-du) : du;
    mb = (dv < 0) ? longint'(-dv) : dv;
    mx = (ma > mb) ? ma : mb;
    s = 0;
    while ((mx >> s) >= (64'd1 << 30)) s++;
    ma = ma >> s;
    mb = mb >> s;
    n = root_floor(ma * ma + mb * mb);
    if (n == 0) n = 1;
    r.image_dir_x = DirW'(unit_part(du, ma, n));
    r.image_dir_y = DirW'(unit_part(dv, mb, n));
    return r;
  endfunction

  // ---------------- driving ----------------
  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx <= RegPoseRow2) pose_rows[idx] = val;
    else if (idx <= RegIntrinsicRow2) k_rows[idx - RegIntrinsicRow0] = val[47:0];
  endtask

  function automatic logic [15:0] rand_extreme();
    case ($urandom_range(2))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_span(int lo, int hi);
    return 16'($urandom_range(hi - lo) + lo);
  endfunction

  // Program a fresh camera of the given style
  task automatic program_camera(int mode);
    logic [63:0] p[3];
    logic [47:0] k[3];
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0: begin
          p[i] = '0;
          p[i][i*16 +: 16] = 16'd16384;
          p[i][63:48] = (i == 2) ? rand_span(256, 4096) : rand_span(-1024, 1024);
          k[i] = {rand_span(0, 10240), 16'd0, rand_span(1600, 16000)};
        end
        1: begin
          for (int j = 0; j < 3; j++)
            p[i][j*16 +: 16] = (i == j) ? rand_span(12000, 16384) : rand_span(-3000, 3000);
          p[i][63:48] = (i == 2) ? rand_span(512, 8192) : rand_span(-2048, 2048);
          k[i] = {rand_span(-2000, 10000), rand_span(-500, 500), rand_span(-20000, 20000)};
        end
        2: begin
          for (int j = 0; j < 4; j++) p[i][j*16 +: 16] = rand_extreme();
          for (int j = 0; j < 3; j++) k[i][j*16 +: 16] = rand_extreme();
        end
        default: begin
          p[i] = {$urandom, $urandom};
          k[i] = 48'({$urandom, $urandom});
        end
      endcase
    end
    write_reg(RegPoseRow0, p[0]);
    write_reg(RegPoseRow1, p[1]);
    write_reg(RegPoseRow2, p[2]);
    write_reg(RegIntrinsicRow0, 64'(k[0]));
    write_reg(RegIntrinsicRow1, 64'(k[1]));
    write_reg(RegIntrinsicRow2, 64'(k[2]));
    // writes past the last register must leave the camera alone
    if (mode == 3) begin
      write_reg(SpareIdx6, {$urandom, $urandom});
      write_reg(SpareIdx7, {$urandom, $urandom});
    end
  endtask

  function automatic lcp_in_t random_line();
    lcp_in_t v;
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) begin
      v = {$urandom, $urandom, $urandom};
      return v;
    end
    v.point_x = rand_span(-8192, 8192);
    v.point_y = rand_span(-8192, 8192);
    v.point_z = rand_span(64, 32767);
    pick = $urandom_range(99);
    if (pick < 5) begin
      v.direction_x = '0;
      v.direction_y = '0;
      v.direction_z = '0;
    end else if (pick < 75) begin
      v.direction_x = rand_span(-512, 512);
      v.direction_y = rand_span(-512, 512);
      v.direction_z = rand_span(-256, 256);
    end else begin
      v.direction_x = 16'($urandom);
      v.direction_y = 16'($urandom);
      v.direction_z = 16'($urandom);
    end
    return v;
  endfunction

  // One input beat; the prediction is queued at the accepting edge
  task automatic send_line(lcp_in_t v, bit typed, lcp_out_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_data = {$urandom, $urandom, $urandom};
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data = v;
    do @(posedge clk_i); while (in_stall);
    pending_pixels.push_back(typed ? typed_res : project_line(v));
    lines_sent++;
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (PipeDelay + 10) @(posedge clk_i);
  endtask

  // ---------------- checking ----------------
  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d (beat %0d)", what, got, want, beats_checked);
    errors++;
  endtask

  always @(posedge clk_i) begin
    lcp_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.image_x !== want.image_x) report("image_x", out_data.image_x, want.image_x);
        if (out_data.image_y !== want.image_y) report("image_y", out_data.image_y, want.image_y);
        if (out_data.image_dir_x !== want.image_dir_x)
          report("image_dir_x", out_data.image_dir_x, want.image_dir_x);
        if (out_data.image_dir_y !== want.image_dir_y)
          report("image_dir_y", out_data.image_dir_y, want.image_dir_y);
        if (out_data.fault !== want.fault) report("fault", out_data.fault, want.fault);
        if (want.fault == FaultDepth) depth_faults++;
        if (want.fault == FaultFlat) flat_faults++;
      end
      beats_checked++;
    end
  end

  // Receiver stalls at random
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, pending_pixels.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- directed table ----------------
  typedef struct {
    lcp_in_t  line;
    bit       camera_set;  // 0: reset camera with typed result, 1: predicted
  } line_row_t;

  line_row_t rows[] = '{
    '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0},
    '{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0},
    '{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, 1'b0},
    '{'{16'h0100, 16'hFF00, 16'h0400, 16'h0010, 16'h0020, 16'h0000}, 1'b0},
    '{'{16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000}, 1'b1},
    '{'{16'h0100, 16'h0200, 16'h0400, 16'h0000, 16'h0000, 16'h0000}, 1'b1},
    '{'{16'h0100, 16'h0200, 16'h0400, 16'h0100, 16'h0000, 16'h0000}, 1'b1},
    '{'{16'h0100, 16'h0200, 16'h0400, 16'h0000, 16'hFF00, 16'h0000}, 1'b1},
    '{'{16'h0100, 16'h0200, 16'h0400, 16'h0001, 16'h0001, 16'h0010}, 1'b1},
    '{'{16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000, 16'h0000, 16'h0000}, 1'b1},
    '{'{16'h8000, 16'h8000, 16'h0001, 16'h7FFF, 16'h7FFF, 16'h0000}, 1'b1},
    '{'{16'h0000, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000}, 1'b1},
    '{'{16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'h8000}, 1'b1},
    '{'{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 1'b1},
    '{'{16'h1234, 16'hEDCB, 16'h0800, 16'h0400, 16'h0400, 16'h0400}, 1'b1},
    '{'{16'h0000, 16'h0000, 16'h7FFF, 16'h0001, 16'h0000, 16'h0000}, 1'b1}
  };

  initial begin
    lcp_out_t zero_res;
    bit camera_up;
    errors = 0;
    lines_sent = 0;
    beats_checked = 0;
    depth_faults = 0;
    flat_faults = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    camera_up = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pose_rows[i] = '0;
      k_rows[i] = '0;
    end
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegPoseRow0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    zero_res = '0;
    zero_res.fault = FaultDepth;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset camera gives zero depth, then a plain pinhole camera
    foreach (rows[r]) begin
      if (rows[r].camera_set && !camera_up) begin
        drain();
        program_camera(0);
        camera_up = 1'b1;
      end
      send_line(rows[r].line, !rows[r].camera_set, zero_res);
    end

    // Random: each camera style under each idling pattern
    for (int m = 0; m < NumModes; m++) begin
      for (int ph = 0; ph < 4; ph++) begin
        drain();
        program_camera(m);
        case (ph)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
          default: begin send_idle_pct = 33; recv_stall_pct = 33; end
        endcase
        for (int n = 0; n < LinesPerPhase; n++) send_line(random_line(), 1'b0, zero_res);
      end
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    $display("%0d lines over %0d camera setups, %0d beats checked", lines_sent,
             NumModes * 4 + 1, beats_checked);
    $display("depth faults %0d, zero-direction faults %0d, mismatches %0d",
             depth_faults, flat_faults, errors);
    if (errors == 0 && pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
